// ===== src/trsc_pkg.sv =====
`default_nettype none

package trsc_pkg;

	// Sizes of the sequence table and of the time and value paths
	localparam int unsigned MaxEntries = 16;
	localparam int unsigned IdxW       = $clog2(MaxEntries);
	localparam int unsigned TimeW      = 24;
	localparam int unsigned AccW       = TimeW + 1;
	localparam int unsigned ValW       = 32;
	localparam int unsigned LenW       = 5;
	localparam int unsigned ElapW      = 16;

	// Port widths
	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned InUserW  = 2;
	localparam int unsigned InDataW  = 80;
	localparam int unsigned OutDataW = 72;

	localparam logic MODE_RAMP     = 1'b0;
	localparam logic MODE_SEQUENCE = 1'b1;

	typedef enum logic [1:0] {
		OP_TICK    = 2'd0,
		OP_RESTART = 2'd1,
		OP_WRITE   = 2'd2,
		OP_NONE    = 2'd3
	} opcode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_MODE     = 3'd0,
		REG_LOOP     = 3'd1,
		REG_ACTIVE   = 3'd2,
		REG_INITIAL  = 3'd3,
		REG_FINAL    = 3'd4,
		REG_STEP     = 3'd5,
		REG_INTERVAL = 3'd6,
		REG_SEQ_LEN  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic                   mode;
		logic                   loop_enable;
		logic                   active;
		logic signed [ValW-1:0] initial_value;
		logic signed [ValW-1:0] final_value;
		logic signed [ValW-1:0] step_value;
		logic [TimeW-1:0]       interval_ticks;
		logic [LenW-1:0]        sequence_length;
	} cfg_t;

	typedef struct packed {
		logic signed [ValW-1:0] value;
		logic [TimeW-1:0]       duration;
	} entry_t;

	typedef struct packed {
		opcode_t          opcode;
		logic [ElapW-1:0] elapsed_ticks;
		logic [IdxW-1:0]  write_index;
		entry_t           wr_entry;
	} item_t;

	typedef struct packed {
		logic signed [ValW-1:0] held_value;
		logic signed [ValW-1:0] entry_value;
		logic [IdxW-1:0]        entry_index;
		logic                   finished;
		logic                   value_changed;
	} result_t;

	// Control from the core to the entry store for one transaction
	typedef struct packed {
		logic            en;
		logic            wr;
		logic [IdxW-1:0] wr_idx;
		logic [IdxW-1:0] pos;
		logic [IdxW-1:0] new_pos;
	} store_ctl_t;

endpackage

`default_nettype wire

// ===== src/trsc_entry_store.sv =====
`default_nettype none

// Sequence table: a memory plus registered copies of the entries at the
// current position, the following position and position zero.
module trsc_entry_store (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire trsc_pkg::store_ctl_t ctl,
	input  wire trsc_pkg::entry_t     wr_entry,
	output trsc_pkg::entry_t          cur_entry,
	output trsc_pkg::entry_t          new_entry
);

	trsc_pkg::entry_t mem [trsc_pkg::MaxEntries];
	trsc_pkg::entry_t cur_q;
	trsc_pkg::entry_t nxt_q;
	trsc_pkg::entry_t zero_q;
	trsc_pkg::entry_t rd_q;
	trsc_pkg::entry_t nxt;
	logic nxt_from_mem_q;

	logic [trsc_pkg::IdxW-1:0] pos_inc;
	logic [trsc_pkg::IdxW-1:0] rd_addr;
	logic moved;
	logic hit_new;
	logic hit_nxt;
	logic hit_zero;

	assign pos_inc  = ctl.pos + trsc_pkg::IdxW'(1);
	assign rd_addr  = ctl.new_pos + trsc_pkg::IdxW'(1);
	assign moved    = ctl.new_pos != ctl.pos;
	assign hit_new  = ctl.wr && (ctl.wr_idx == ctl.new_pos);
	assign hit_nxt  = ctl.wr && (ctl.wr_idx == pos_inc);
	assign hit_zero = ctl.wr && (ctl.wr_idx == '0);

	// Entry after the current one: freshly read, or held since the last move
	assign nxt = nxt_from_mem_q ? rd_q : nxt_q;

	assign cur_entry = cur_q;

	// Select the entry at the position this transaction leaves behind
	always_comb begin
		if (hit_new) begin
			new_entry = wr_entry;
		end else if (ctl.new_pos == ctl.pos) begin
			new_entry = cur_q;
		end else if (ctl.new_pos == pos_inc) begin
			new_entry = nxt;
		end else begin
			new_entry = zero_q;
		end
	end

	// Write the table and fetch the entry following a new position
	always_ff @(posedge clk) begin
		if (ctl.en && ctl.wr) begin
			mem[ctl.wr_idx] <= wr_entry;
		end
		if (ctl.en && moved) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Keep the shadow copies in step with writes and moves
	always_ff @(posedge clk) begin
		if (ctl.en) begin
			cur_q <= new_entry;
			if (hit_zero) begin
				zero_q <= wr_entry;
			end
			if (!moved) begin
				nxt_q <= hit_nxt ? wr_entry : nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nxt_from_mem_q <= 1'b0;
		end else if (ctl.en) begin
			nxt_from_mem_q <= moved;
		end
	end

endmodule

`default_nettype wire

// ===== src/trsc_core.sv =====
`default_nettype none

// Ramp and sequence state with the next-state logic for one transaction.
module trsc_core (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire trsc_pkg::cfg_t       cfg,
	input  wire logic                 en,
	input  wire trsc_pkg::item_t      item,
	input  wire trsc_pkg::entry_t     cur_entry,
	input  wire trsc_pkg::entry_t     new_entry,
	output trsc_pkg::store_ctl_t      store_ctl,
	output trsc_pkg::result_t         result,
	output logic                      done
);

	logic [trsc_pkg::AccW-1:0]         acc_q;
	logic signed [trsc_pkg::ValW-1:0]  value_q;
	logic [trsc_pkg::IdxW-1:0]         pos_q;
	logic                              done_q;

	logic [trsc_pkg::AccW-1:0]         acc_d;
	logic signed [trsc_pkg::ValW-1:0]  value_d;
	logic [trsc_pkg::IdxW-1:0]         pos_d;
	logic                              done_d;
	logic                              changed;

	logic [trsc_pkg::AccW:0]           acc_sum;
	logic [trsc_pkg::AccW-1:0]         acc_sat;
	logic [trsc_pkg::TimeW-1:0]        limit;
	logic                              reached;
	logic signed [trsc_pkg::ValW-1:0]  ramp_sum;
	logic                              away;
	logic                              at_end;
	logic [trsc_pkg::LenW-1:0]         idx_next;
	logic [trsc_pkg::LenW-1:0]         len_used;
	logic                              wrap;

	// Accumulate elapsed time, saturating at the accumulator maximum
	assign acc_sum = {1'b0, acc_q} + (trsc_pkg::AccW + 1)'(item.elapsed_ticks);
	assign acc_sat = acc_sum[trsc_pkg::AccW] ? '1 : acc_sum[trsc_pkg::AccW-1:0];
	assign limit   = (cfg.mode == trsc_pkg::MODE_SEQUENCE) ? cur_entry.duration
	                                                       : cfg.interval_ticks;
	assign reached = acc_sat >= trsc_pkg::AccW'(limit);

	// Ramp step and end test
	assign ramp_sum = value_q + cfg.step_value;
	assign away = ((cfg.initial_value < cfg.final_value) && (cfg.step_value < 0)) ||
	              ((cfg.initial_value > cfg.final_value) && (cfg.step_value > 0));
	assign at_end = ((cfg.step_value > 0) && (ramp_sum >= cfg.final_value)) ||
	                ((cfg.step_value < 0) && (ramp_sum <= cfg.final_value));

	// Sequence advance against the clamped length
	assign idx_next = {1'b0, pos_q} + trsc_pkg::LenW'(1);
	always_comb begin
		if (cfg.sequence_length == '0) begin
			len_used = trsc_pkg::LenW'(1);
		end else if (cfg.sequence_length > trsc_pkg::LenW'(trsc_pkg::MaxEntries)) begin
			len_used = trsc_pkg::LenW'(trsc_pkg::MaxEntries);
		end else begin
			len_used = cfg.sequence_length;
		end
	end
	assign wrap = idx_next >= len_used;

	// Next state for the transaction in flight
	always_comb begin
		acc_d   = acc_q;
		value_d = value_q;
		pos_d   = pos_q;
		done_d  = done_q;
		changed = 1'b0;
		unique case (item.opcode)
			trsc_pkg::OP_TICK: begin
				if (cfg.active && !done_q) begin
					acc_d = acc_sat;
					if (reached) begin
						acc_d   = '0;
						changed = 1'b1;
						if (cfg.mode == trsc_pkg::MODE_SEQUENCE) begin
							value_d = cur_entry.value;
							pos_d   = idx_next[trsc_pkg::IdxW-1:0];
							if (wrap) begin
								if (cfg.loop_enable) begin
									pos_d = '0;
								end else begin
									done_d = 1'b1;
								end
							end
						end else begin
							value_d = ramp_sum;
							if (!away && at_end) begin
								if (cfg.loop_enable) begin
									value_d = cfg.initial_value;
								end else begin
									done_d = 1'b1;
								end
							end
						end
					end
				end
			end
			trsc_pkg::OP_RESTART: begin
				done_d  = 1'b0;
				pos_d   = '0;
				acc_d   = '0;
				value_d = cfg.initial_value;
			end
			trsc_pkg::OP_WRITE: begin
			end
			trsc_pkg::OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	assign store_ctl.en      = en;
	assign store_ctl.wr      = item.opcode == trsc_pkg::OP_WRITE;
	assign store_ctl.wr_idx  = item.write_index;
	assign store_ctl.pos     = pos_q;
	assign store_ctl.new_pos = pos_d;

	assign result.held_value    = value_d;
	assign result.entry_value   = (cfg.mode == trsc_pkg::MODE_SEQUENCE) ? new_entry.value
	                                                                    : value_d;
	assign result.entry_index   = pos_d;
	assign result.finished      = done_d;
	assign result.value_changed = changed;

	assign done = done_q;

	// Commit state when the transaction moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			value_q <= '0;
			pos_q   <= '0;
			done_q  <= 1'b0;
		end else if (en) begin
			acc_q   <= acc_d;
			value_q <= value_d;
			pos_q   <= pos_d;
			done_q  <= done_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/timed_ramp_and_sequence_counter.sv =====
// Path: an accepted input goes to the input register, its result to the result register.
// Throughput: one transaction per cycle unless m_tready stalls; the input register feeds
// the core and the result register in one step; each item sees its predecessor's state.
// Reset: arst_n clears control state, the ramp value, position, finished flag and
// accumulator at once; configuration returns to its defaults; the table stays unwritten.
`default_nettype none

module timed_ramp_and_sequence_counter (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// input stream
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// elapsed_ticks, write_index, write_value, write_duration, zero pad
	input  wire logic [trsc_pkg::InDataW-1:0]      s_tdata,
	// opcode
	input  wire logic [trsc_pkg::InUserW-1:0]      s_tuser,
	// result stream
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// held_value, entry_value, entry_index, finished, value_changed, zero pad
	output logic [trsc_pkg::OutDataW-1:0]          m_tdata,
	// configuration writes
	input  wire logic                              cfg_we,
	input  wire logic [trsc_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [trsc_pkg::CfgDataW-1:0]     cfg_wdata
);

	trsc_pkg::cfg_t       cfg_q;
	trsc_pkg::item_t      in_item;
	trsc_pkg::item_t      item_s1;
	logic                 valid_s1;
	trsc_pkg::result_t    result;
	trsc_pkg::result_t    res_q;
	logic                 out_valid_q;
	logic                 advance;
	logic                 en;
	logic                 done;
	trsc_pkg::store_ctl_t store_ctl;
	trsc_pkg::entry_t     cur_entry;
	trsc_pkg::entry_t     new_entry;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode            <= trsc_pkg::MODE_RAMP;
			cfg_q.loop_enable     <= 1'b0;
			cfg_q.active          <= 1'b0;
			cfg_q.initial_value   <= '0;
			cfg_q.final_value     <= '0;
			cfg_q.step_value      <= '0;
			cfg_q.interval_ticks  <= '0;
			cfg_q.sequence_length <= trsc_pkg::LenW'(1);
		end else if (cfg_we) begin
			unique case (trsc_pkg::cfg_reg_t'(cfg_index))
				trsc_pkg::REG_MODE:     cfg_q.mode            <= cfg_wdata[0];
				trsc_pkg::REG_LOOP:     cfg_q.loop_enable     <= cfg_wdata[0];
				trsc_pkg::REG_ACTIVE:   cfg_q.active          <= cfg_wdata[0];
				trsc_pkg::REG_INITIAL:  cfg_q.initial_value   <= cfg_wdata;
				trsc_pkg::REG_FINAL:    cfg_q.final_value     <= cfg_wdata;
				trsc_pkg::REG_STEP:     cfg_q.step_value      <= cfg_wdata;
				trsc_pkg::REG_INTERVAL: cfg_q.interval_ticks  <= cfg_wdata[trsc_pkg::TimeW-1:0];
				trsc_pkg::REG_SEQ_LEN:  cfg_q.sequence_length <= cfg_wdata[trsc_pkg::LenW-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the input transaction
	assign in_item.opcode            = trsc_pkg::opcode_t'(s_tuser);
	assign in_item.elapsed_ticks     = s_tdata[15:0];
	assign in_item.write_index       = s_tdata[19:16];
	assign in_item.wr_entry.value    = s_tdata[51:20];
	assign in_item.wr_entry.duration = s_tdata[75:52];

	// Handshake: the input stage moves whenever the result register can take a result
	assign advance  = !out_valid_q || m_tready;
	assign en       = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item;
		end
	end

	trsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.en        (en),
		.item      (item_s1),
		.cur_entry (cur_entry),
		.new_entry (new_entry),
		.store_ctl (store_ctl),
		.result    (result),
		.done      (done)
	);

	trsc_entry_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (store_ctl),
		.wr_entry  (item_s1.wr_entry),
		.cur_entry (cur_entry),
		.new_entry (new_entry)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, res_q.value_changed, res_q.finished, res_q.entry_index,
	                   res_q.entry_value, res_q.held_value};

`ifndef SYNTH
	// A restart always reports position zero, not finished, no change
	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		en && item_s1.opcode == trsc_pkg::OP_RESTART |=>
			out_valid_q && !res_q.finished && res_q.entry_index == '0 &&
			!res_q.value_changed)
		else $error("restart did not clear the run state");

	// A finished run ignores ticks
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		en && item_s1.opcode == trsc_pkg::OP_TICK && done |=>
			res_q.finished && !res_q.value_changed)
		else $error("tick changed a finished run");

	// In ramp mode the entry value mirrors the held value
	a_ramp_entry: assert property (@(posedge clk) disable iff (!arst_n)
		en && cfg_q.mode == trsc_pkg::MODE_RAMP |=>
			res_q.entry_value == res_q.held_value)
		else $error("ramp result shows a table entry");
`endif

endmodule

`default_nettype wire
